FILE: hdl/lzwe_pkg.sv
package lzwe_pkg;

  // Widest code the packer and the command path carry.
  localparam int unsigned CODE_W_MAX = 12;
  // Packer accumulator: up to 7 leftover bits plus one widest code.
  localparam int unsigned ACC_W      = 7 + CODE_W_MAX;
  localparam int unsigned CNT_W      = 5;
  // Dictionary generation tag; tag zero marks a swept (empty) entry.
  localparam int unsigned EPOCH_W    = 3;

  typedef logic [CODE_W_MAX-1:0] code_t;
  typedef logic [3:0]            width_t;
  typedef logic [EPOCH_W-1:0]    epoch_t;

  localparam code_t  CODE_CLEAR = 12'd256;
  localparam code_t  CODE_EOD   = 12'd257;
  localparam code_t  CODE_FIRST = 12'd258;
  localparam width_t WIDTH_INIT = 4'd9;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_PROBE,
    ST_MISS,
    ST_CLR,
    ST_FIN_PRE,
    ST_FIN_EOD,
    ST_PAD,
    ST_END
  } state_e;

  // One command per cycle from the sequencer to the packer, sent only while the packer is ready.
  typedef struct packed {
    logic   load;   // append code at width
    logic   pad;    // round pending bits up to a byte
    logic   last;   // close the request: flag the held byte as last
    logic   fin;    // with last: the request closes the stream
    code_t  code;
    width_t width;
  } pk_cmd_t;

endpackage

FILE: hdl/lzw_stream_encoder_top.sv
// LZW stream encoder with CLEAR/EOD code framing and MSB-first packing.
// Input channel s_axis: one request per byte; tuser = 1 asks to finish the
// stream (emit prefix, EOD, zero padding), tuser = 0 carries a data byte.
// Output channel m_axis: packed code bytes; tlast marks the last byte that one
// request produces, tuser marks the final byte of a stream.
// On a dictionary hit a request passes IDLE and PROBE; a miss adds MISS, then
// END (CLR, and a sweep if due, first when the dictionary is full), and each
// hash collision adds a PROBE step. The dictionary memory takes one write and
// one registered read per cycle; the packer drains one byte per cycle while the
// receiver keeps up. Bytes go from the accumulator to a hold slot, then out.
// The dictionary is emptied by bumping a generation tag; every seventh clear,
// and right after reset, a sweep rewrites all TABLE_SIZE entries while
// s_axis_tready stays low.
// When the receiver stalls, bytes collect in one hold slot and the output
// register, and the sequencer waits for the packer before its next code.
module lzw_stream_encoder_top #(
  parameter int unsigned CODE_BITS  = 12,
  parameter int unsigned TABLE_SIZE = 8192
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tuser,   // [0] action
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,   // run_last
  output logic       m_axis_tuser    // [0] stream_end
);

  localparam int unsigned AW = $clog2(TABLE_SIZE);
  localparam int unsigned CB = CODE_BITS;
  localparam int unsigned LW = CODE_BITS + 1;
  localparam int unsigned TW = lzwe_pkg::EPOCH_W;
  // Entry: {tag, byte, prefix, code}
  localparam int unsigned EW = TW + 8 + 2 * CODE_BITS;

  localparam logic [AW-1:0] SlotLast  = AW'(TABLE_SIZE - 1);
  localparam logic [LW-1:0] LimitInit = LW'((1 << 9) - 1);

  logic [EW-1:0] mem [TABLE_SIZE];
  logic [EW-1:0] rd_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [EW-1:0] mem_wd;
  logic [AW-1:0] rd_addr;

  lzwe_pkg::state_e state_q, state_d;
  logic [CB-1:0]     prefix_q, prefix_d;
  logic [CB-1:0]     nfc_q, nfc_d;
  lzwe_pkg::width_t  width_q, width_d;
  logic [LW-1:0]     limit_q, limit_d;
  logic              cp_q, cp_d;
  logic              started_q, started_d;
  logic              fin_q, fin_d;
  logic [7:0]        c_q, c_d;
  logic [AW-1:0]     slot_q, slot_d;
  logic [AW-1:0]     sweep_q, sweep_d;
  logic              sweep_mid_q, sweep_mid_d;
  lzwe_pkg::epoch_t  epoch_q, epoch_d;

  lzwe_pkg::pk_cmd_t cmd;
  logic              pk_rdy;

  logic              accept;
  logic [AW-1:0]     hash_in;
  logic [AW-1:0]     slot_nx;
  logic [CB-1:0]     rd_code;
  logic [CB-1:0]     rd_pref;
  logic [7:0]        rd_byte;
  lzwe_pkg::epoch_t  rd_tag;
  logic              probe_hit;
  logic              probe_empty;
  logic              dict_full;

  // Code width update after each emitted code.
  lzwe_pkg::width_t  ae_width;
  logic [LW-1:0]     ae_limit;
  logic              ae_cp;

  always_comb begin
    ae_width = width_q;
    ae_limit = limit_q;
    ae_cp    = 1'b0;
    if (cp_q) begin
      ae_width = lzwe_pkg::WIDTH_INIT;
      ae_limit = LimitInit;
    end else if (({1'b0, nfc_q} >= limit_q) && (width_q < 4'(CODE_BITS))) begin
      ae_width = width_q + 4'd1;
      if (ae_width == 4'(CODE_BITS)) begin
        ae_limit = LW'(1) << CODE_BITS;
      end else begin
        ae_limit = (LW'(1) << ae_width) - LW'(1);
      end
    end
  end

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign hash_in   = AW'((12'(s_axis_tdata) << 4) ^ 12'(prefix_q));
  assign slot_nx   = (slot_q == SlotLast) ? '0 : slot_q + AW'(1);
  assign rd_code   = rd_q[CB-1:0];
  assign rd_pref   = rd_q[2*CB-1:CB];
  assign rd_byte   = rd_q[2*CB+7:2*CB];
  assign rd_tag    = rd_q[EW-1:EW-TW];
  assign probe_empty = rd_tag != epoch_q;
  assign probe_hit   = !probe_empty && (rd_byte == c_q) && (rd_pref == prefix_q);
  assign dict_full   = nfc_q == '1;

  always_comb begin
    state_d     = state_q;
    prefix_d    = prefix_q;
    nfc_d       = nfc_q;
    width_d     = width_q;
    limit_d     = limit_q;
    cp_d        = cp_q;
    started_d   = started_q;
    fin_d       = fin_q;
    c_d         = c_q;
    slot_d      = slot_q;
    sweep_d     = sweep_q;
    sweep_mid_d = sweep_mid_q;
    epoch_d     = epoch_q;
    mem_we      = 1'b0;
    mem_wa      = slot_q;
    mem_wd      = {epoch_q, c_q, prefix_q, nfc_q};
    rd_addr     = slot_q;
    cmd         = '0;
    cmd.width   = width_q;
    s_axis_tready = 1'b0;

    unique case (state_q)
      lzwe_pkg::ST_SWEEP: begin
        mem_we  = 1'b1;
        mem_wa  = sweep_q;
        mem_wd  = '0;
        sweep_d = sweep_q + AW'(1);
        if (sweep_q == SlotLast) begin
          sweep_d     = '0;
          sweep_mid_d = 1'b0;
          state_d     = sweep_mid_q ? lzwe_pkg::ST_END : lzwe_pkg::ST_IDLE;
        end
      end
      lzwe_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        rd_addr       = hash_in;
        if (accept) begin
          if (s_axis_tuser) begin
            // Finish with no stream open yields nothing.
            if (started_q) begin
              fin_d   = 1'b1;
              state_d = lzwe_pkg::ST_FIN_PRE;
            end
          end else if (!started_q) begin
            nfc_d     = CB'(lzwe_pkg::CODE_FIRST);
            width_d   = lzwe_pkg::WIDTH_INIT;
            limit_d   = LimitInit;
            cp_d      = 1'b0;
            prefix_d  = CB'(s_axis_tdata);
            started_d = 1'b1;
            fin_d     = 1'b0;
            state_d   = lzwe_pkg::ST_CLR;
          end else begin
            c_d     = s_axis_tdata;
            slot_d  = hash_in;
            fin_d   = 1'b0;
            state_d = lzwe_pkg::ST_PROBE;
          end
        end
      end
      lzwe_pkg::ST_PROBE: begin
        if (probe_hit) begin
          prefix_d = rd_code;
          state_d  = lzwe_pkg::ST_IDLE;
        end else if (probe_empty) begin
          mem_we  = !dict_full;
          state_d = lzwe_pkg::ST_MISS;
        end else begin
          // Collision: step to the next slot.
          slot_d  = slot_nx;
          rd_addr = slot_nx;
        end
      end
      lzwe_pkg::ST_MISS: begin
        if (pk_rdy) begin
          cmd.load = 1'b1;
          cmd.code = lzwe_pkg::code_t'(prefix_q);
          width_d  = ae_width;
          limit_d  = ae_limit;
          cp_d     = ae_cp;
          prefix_d = CB'(c_q);
          if (!dict_full) begin
            nfc_d   = nfc_q + CB'(1);
            state_d = lzwe_pkg::ST_END;
          end else begin
            nfc_d   = CB'(lzwe_pkg::CODE_FIRST);
            cp_d    = 1'b1;
            state_d = lzwe_pkg::ST_CLR;
          end
        end
      end
      lzwe_pkg::ST_CLR: begin
        if (pk_rdy) begin
          cmd.load = 1'b1;
          cmd.code = lzwe_pkg::CODE_CLEAR;
          width_d  = ae_width;
          limit_d  = ae_limit;
          cp_d     = ae_cp;
          // Drop the dictionary: new tag, or a full sweep once tags run out.
          if (epoch_q == '1) begin
            epoch_d     = lzwe_pkg::epoch_t'(1);
            sweep_mid_d = 1'b1;
            state_d     = lzwe_pkg::ST_SWEEP;
          end else begin
            epoch_d = epoch_q + lzwe_pkg::epoch_t'(1);
            state_d = lzwe_pkg::ST_END;
          end
        end
      end
      lzwe_pkg::ST_FIN_PRE: begin
        if (pk_rdy) begin
          cmd.load = 1'b1;
          cmd.code = lzwe_pkg::code_t'(prefix_q);
          width_d  = ae_width;
          limit_d  = ae_limit;
          cp_d     = ae_cp;
          state_d  = lzwe_pkg::ST_FIN_EOD;
        end
      end
      lzwe_pkg::ST_FIN_EOD: begin
        if (pk_rdy) begin
          cmd.load = 1'b1;
          cmd.code = lzwe_pkg::CODE_EOD;
          width_d  = ae_width;
          limit_d  = ae_limit;
          cp_d     = ae_cp;
          state_d  = lzwe_pkg::ST_PAD;
        end
      end
      lzwe_pkg::ST_PAD: begin
        if (pk_rdy) begin
          cmd.pad   = 1'b1;
          started_d = 1'b0;
          state_d   = lzwe_pkg::ST_END;
        end
      end
      lzwe_pkg::ST_END: begin
        if (pk_rdy) begin
          cmd.last = 1'b1;
          cmd.fin  = fin_q;
          state_d  = lzwe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lzwe_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lzwe_pkg::ST_SWEEP;
      prefix_q    <= '0;
      nfc_q       <= CB'(lzwe_pkg::CODE_FIRST);
      width_q     <= lzwe_pkg::WIDTH_INIT;
      limit_q     <= LimitInit;
      cp_q        <= 1'b0;
      started_q   <= 1'b0;
      fin_q       <= 1'b0;
      sweep_q     <= '0;
      sweep_mid_q <= 1'b0;
      epoch_q     <= lzwe_pkg::epoch_t'(1);
    end else begin
      state_q     <= state_d;
      prefix_q    <= prefix_d;
      nfc_q       <= nfc_d;
      width_q     <= width_d;
      limit_q     <= limit_d;
      cp_q        <= cp_d;
      started_q   <= started_d;
      fin_q       <= fin_d;
      sweep_q     <= sweep_d;
      sweep_mid_q <= sweep_mid_d;
      epoch_q     <= epoch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q    <= c_d;
    slot_q <= slot_d;
  end

  // Dictionary memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[rd_addr];
  end

  lzwe_packer u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .rdy_o       (pk_rdy),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_end_o   (m_axis_tuser)
  );

endmodule

FILE: hdl/lzwe_packer.sv
module lzwe_packer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lzwe_pkg::pk_cmd_t cmd_i,
  output logic             rdy_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_data_o,
  output logic             out_last_o,
  output logic             out_end_o
);

  localparam int unsigned AccW = lzwe_pkg::ACC_W;
  localparam int unsigned CntW = lzwe_pkg::CNT_W;

  // Bits are kept left aligned; everything below the count is zero.
  logic [AccW-1:0] buf_q, buf_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      hold_q, hold_d;
  logic            hold_v_q, hold_v_d;
  logic            out_v_q, out_v_d;
  logic [7:0]      out_q, out_d;
  logic            last_q, last_d;
  logic            end_q, end_d;

  logic            out_free;
  logic            have_byte;
  logic [lzwe_pkg::CODE_W_MAX-1:0] masked;
  logic [CntW-1:0] sh;

  always_comb begin
    out_free  = !out_v_q || out_ready_i;
    have_byte = cnt_q >= CntW'(8);
    rdy_o     = !have_byte && (!hold_v_q || out_free);
    masked    = cmd_i.code & ((lzwe_pkg::CODE_W_MAX'(1) << cmd_i.width)
                              - lzwe_pkg::CODE_W_MAX'(1));
    sh        = CntW'(AccW) - cnt_q - CntW'(cmd_i.width);

    buf_d    = buf_q;
    cnt_d    = cnt_q;
    hold_d   = hold_q;
    hold_v_d = hold_v_q;
    out_v_d  = out_v_q;
    out_d    = out_q;
    last_d   = last_q;
    end_d    = end_q;

    if (out_v_q && out_ready_i) begin
      out_v_d = 1'b0;
    end

    if (have_byte && (!hold_v_q || out_free)) begin
      // Peel the top byte; the previously held byte is not the last one.
      if (hold_v_q) begin
        out_v_d = 1'b1;
        out_d   = hold_q;
        last_d  = 1'b0;
        end_d   = 1'b0;
      end
      hold_d   = buf_q[AccW-1 -: 8];
      hold_v_d = 1'b1;
      buf_d    = buf_q << 8;
      cnt_d    = cnt_q - CntW'(8);
    end else if (rdy_o) begin
      if (cmd_i.load) begin
        buf_d = buf_q | (AccW'(masked) << sh);
        cnt_d = cnt_q + CntW'(cmd_i.width);
      end else if (cmd_i.pad) begin
        if (cnt_q != '0) begin
          cnt_d = CntW'(8);
        end
      end else if (cmd_i.last) begin
        if (hold_v_q) begin
          out_v_d  = 1'b1;
          out_d    = hold_q;
          last_d   = 1'b1;
          end_d    = cmd_i.fin;
          hold_v_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q    <= '0;
      cnt_q    <= '0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      buf_q    <= buf_d;
      cnt_q    <= cnt_d;
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    out_q  <= out_d;
    last_q <= last_d;
    end_q  <= end_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;
  assign out_last_o  = last_q;
  assign out_end_o   = end_q;

endmodule

FILE: bench/tb_lzw_stream_encoder_top.sv
`timescale 1ns / 100ps

module tb_lzw_stream_encoder_top;

  localparam logic ACT_DATA   = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  localparam int unsigned TOP_CODE_BITS = 12;
  localparam int unsigned CODE_SPAN     = 1 << TOP_CODE_BITS;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned TAIL_CYCLES   = 64;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       fin;
  } out_byte_t;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tuser;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic       m_axis_tuser;

  // Encoder state mirror.
  lzwe_pkg::code_t dict_map [logic [19:0]];
  lzwe_pkg::code_t cur_prefix;
  int unsigned next_code;
  int unsigned cur_width;
  int unsigned width_top;
  bit          clear_armed;
  bit          in_stream;
  int unsigned bit_hold;
  int unsigned bit_cnt;

  logic [7:0]  req_bytes[$];
  out_byte_t   packed_bytes_q[$];
  out_byte_t   want;

  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  int unsigned idle_pct;
  int unsigned hold_len;

  lzw_stream_encoder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Append one code MSB-first at the current width; collect full bytes.
  function automatic void pack_code(input int unsigned code);
    int unsigned acc;
    int unsigned cnt;
    acc = (bit_hold << cur_width) | (code & ((1 << cur_width) - 1));
    cnt = bit_cnt + cur_width;
    while (cnt >= 8) begin
      cnt -= 8;
      req_bytes.push_back(8'(acc >> cnt));
    end
    bit_hold = acc & ((1 << cnt) - 1);
    bit_cnt  = cnt;
  endfunction

  // Width update after each emitted code: restart after CLEAR, or grow early.
  function automatic void bump_width();
    if (clear_armed) begin
      cur_width   = 32'(lzwe_pkg::WIDTH_INIT);
      width_top   = (1 << lzwe_pkg::WIDTH_INIT) - 1;
      clear_armed = 1'b0;
    end else if (next_code >= width_top && cur_width < TOP_CODE_BITS) begin
      cur_width++;
      width_top = (cur_width == TOP_CODE_BITS) ? CODE_SPAN : (1 << cur_width) - 1;
    end
  endfunction

  function automatic void encoder_reset();
    dict_map.delete();
    cur_prefix  = '0;
    next_code   = 32'(lzwe_pkg::CODE_FIRST);
    cur_width   = 32'(lzwe_pkg::WIDTH_INIT);
    width_top   = (1 << lzwe_pkg::WIDTH_INIT) - 1;
    clear_armed = 1'b0;
    in_stream   = 1'b0;
    bit_hold    = 0;
    bit_cnt     = 0;
  endfunction

  // Compute the packed bytes one request produces and queue them in order.
  function automatic void encode_request(input logic act, input logic [7:0] c);
    logic [19:0] key;
    bit          closing;
    closing = 1'b0;
    req_bytes.delete();
    if (act == ACT_FINISH) begin
      if (in_stream) begin
        pack_code(32'(cur_prefix));
        bump_width();
        pack_code(32'(lzwe_pkg::CODE_EOD));
        bump_width();
        if (bit_cnt > 0) req_bytes.push_back(8'(bit_hold << (8 - bit_cnt)));
        bit_hold  = 0;
        bit_cnt   = 0;
        in_stream = 1'b0;
        closing   = 1'b1;
      end
    end else if (!in_stream) begin
      dict_map.delete();
      next_code   = 32'(lzwe_pkg::CODE_FIRST);
      cur_width   = 32'(lzwe_pkg::WIDTH_INIT);
      width_top   = (1 << lzwe_pkg::WIDTH_INIT) - 1;
      clear_armed = 1'b0;
      bit_hold    = 0;
      bit_cnt     = 0;
      pack_code(32'(lzwe_pkg::CODE_CLEAR));
      bump_width();
      cur_prefix = lzwe_pkg::code_t'(c);
      in_stream  = 1'b1;
    end else begin
      key = {c, cur_prefix};
      if (dict_map.exists(key)) begin
        cur_prefix = dict_map[key];
      end else begin
        pack_code(32'(cur_prefix));
        bump_width();
        cur_prefix = lzwe_pkg::code_t'(c);
        if (next_code < CODE_SPAN - 1) begin
          dict_map[key] = lzwe_pkg::code_t'(next_code);
          next_code++;
        end else begin
          // Dictionary full: send CLEAR in place of a new entry.
          dict_map.delete();
          next_code   = 32'(lzwe_pkg::CODE_FIRST);
          clear_armed = 1'b1;
          pack_code(32'(lzwe_pkg::CODE_CLEAR));
          bump_width();
        end
      end
    end
    foreach (req_bytes[i]) begin
      packed_bytes_q.push_back('{data: req_bytes[i],
                                 last: (i == req_bytes.size() - 1),
                                 fin:  closing && (i == req_bytes.size() - 1)});
    end
  endfunction

  // Offer one request; entered and left at a falling edge.
  task automatic send_req(input logic act, input logic [7:0] data_v);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= data_v;
    do @(posedge clk_i); while (!s_axis_tready);
    encode_request(act, data_v);
    @(negedge clk_i);
  endtask

  // Hold the sender until every predicted byte has come out.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (packed_bytes_q.size() != 0) @(negedge clk_i);
  endtask

  // Sink side: random stalls, plus a long hold when a test asks for one.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_len > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_len) @(negedge clk_i);
        hold_len = 0;
        m_axis_tready <= 1'b1;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare every accepted output byte with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (packed_bytes_q.size() == 0) begin
        $error("unexpected output byte %02h (last %0b, end %0b)",
               m_axis_tdata, m_axis_tlast, m_axis_tuser);
        mismatch_cnt++;
      end else begin
        want = packed_bytes_q.pop_front();
        if (m_axis_tdata !== want.data) begin
          $error("out_byte: expected %02h, got %02h", want.data, m_axis_tdata);
          mismatch_cnt++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("run_last: expected %0b, got %0b", want.last, m_axis_tlast);
          mismatch_cnt++;
        end
        if (m_axis_tuser !== want.fin) begin
          $error("stream_end: expected %0b, got %0b", want.fin, m_axis_tuser);
          mismatch_cnt++;
        end
      end
    end
  end

  // Finish with nothing open, twice; data field is don't-care here.
  task automatic test_empty_finish();
    send_req(ACT_FINISH, 8'hA5);
    send_req(ACT_FINISH, 8'h5A);
  endtask

  // Byte extremes, hits on a repeated byte, a stream that ends on a byte
  // boundary (no pad), and a repeated finish after a closed stream.
  task automatic test_short_streams();
    logic [7:0] six[6];
    six = '{8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA};
    send_req(ACT_DATA, 8'h00);
    send_req(ACT_FINISH, 8'hFF);
    repeat (4) send_req(ACT_DATA, 8'hFF);
    send_req(ACT_FINISH, 8'h00);
    foreach (six[i]) send_req(ACT_DATA, six[i]);
    send_req(ACT_FINISH, 8'h00);
    send_req(ACT_FINISH, 8'hFF);
  endtask

  // 253 new entries bring the next code to 511: the width grows right after
  // the prefix goes out at finish, so EOD leaves at 10 bits.
  task automatic test_width_at_finish();
    for (int unsigned b = 0; b < 254; b++) send_req(ACT_DATA, 8'(b));
    send_req(ACT_FINISH, 8'h00);
  endtask

  // Long random stream: walk the width up to 12 bits and fill the
  // dictionary until CLEAR replaces an entry.
  task automatic test_long_stream();
    idle_pct = 4;
    repeat (4600) send_req(ACT_DATA, 8'($urandom));
    send_req(ACT_FINISH, 8'($urandom));
    wait_drained();
  endtask

  // Hold the sink off for a long stretch while the sender keeps offering,
  // so the encoder backs up and stalls its input.
  task automatic test_sink_backpressure();
    idle_pct = 0;
    hold_len = 300;
    repeat (40) send_req(ACT_DATA, 8'($urandom_range(0, 7)));
    send_req(ACT_FINISH, 8'($urandom));
    wait_drained();
  endtask

  // Mostly complete streams with random content, mixed with lone finishes,
  // unterminated runs and full drains; no idling in the last quarter.
  task automatic test_random_streams(input int unsigned n_items);
    int unsigned sent;
    int unsigned mode;
    int unsigned len;
    logic [7:0]  base;
    logic [7:0]  mask;
    sent = 0;
    idle_pct = 25;
    while (sent < n_items) begin
      if (sent >= (n_items * 3) / 4) idle_pct = 0;
      mode = $urandom_range(0, 19);
      if (mode == 0) begin
        send_req(ACT_FINISH, 8'($urandom));
        sent++;
      end else if (mode == 1) begin
        len = $urandom_range(1, 6);
        repeat (len) send_req(ACT_DATA, 8'($urandom));
        sent += len;
      end else if (mode == 2) begin
        wait_drained();
      end else begin
        len  = $urandom_range(1, 24);
        base = 8'($urandom);
        mask = $urandom_range(0, 1) ? 8'h03 : 8'hFF;
        repeat (len) send_req(ACT_DATA, base ^ (8'($urandom) & mask));
        send_req(ACT_FINISH, 8'($urandom));
        sent += len + 1;
      end
    end
    wait_drained();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_DATA;
    m_axis_tready = 1'b0;
    mismatch_cnt  = 0;
    idle_pct      = 0;
    hold_len      = 0;
    encoder_reset();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    idle_pct = 30;
    test_empty_finish();
    test_short_streams();
    test_width_at_finish();
    wait_drained();
    test_long_stream();
    test_sink_backpressure();
    test_random_streams(180);

    // Let any stray output show up before judging.
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (packed_bytes_q.size() != 0) begin
      $error("%0d predicted output bytes never arrived", packed_bytes_q.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
